>>> hw/rtl/ffsp_pkg.sv
package ffsp_pkg;

    // Width of a slot index and of the in-use count.
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;

    // Register index of the capacity register (paddr[2]).
    localparam logic CFG_IDX_LIMIT = 1'b0;

    // Reset value of the capacity register.
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 9'd256;

    // Operation codes carried on the input tuser.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Error codes reported with each result.
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_EXHAUSTED = 2'd1,
        ERR_NOT_USED  = 2'd2,
        ERR_RANGE     = 2'd3
    } ffsp_err_t;

    // Control sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ffsp_state_t;

    // Request from the controller to the next-slot table.
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [SLOT_W-1:0] wr_data;
        logic              clear;
    } ffsp_tbl_req_t;

endpackage

>>> hw/rtl/ffsp_table.sv
module ffsp_table #(
    parameter int DEPTH = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ffsp_pkg::ffsp_tbl_req_t req,
    output logic [7:0]             rd_data
);
    import ffsp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SLOT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [SLOT_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] rd_dflt_reg;

    logic rd_in_range;
    logic wr_in_range;

    assign rd_in_range = (32'(req.rd_addr) < DEPTH);
    assign wr_in_range = (32'(req.wr_addr) < DEPTH);

    // Storage array, written at one address and read at one address a cycle.
    always_ff @(posedge clk)
    begin
        if (req.wr_en && wr_in_range)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
            rd_dflt_reg <= rd_in_range ? (req.rd_addr + 8'd1) : '0;
        end
    end

    // Per-entry valid bits; an entry never written since the last rebuild
    // reads as the chained value, its own index plus one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en && wr_in_range)
            begin
                valid_reg[req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= rd_in_range && valid_reg[req.rd_addr[AW-1:0]];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : rd_dflt_reg;

endmodule

>>> hw/rtl/fifo_free_list_slot_pool_top.sv
// Slot pool allocator with a first-in, first-out free list.
// A result is registered in the output stage by the update state, which waits
// while an earlier result is unaccepted. A new transaction is taken only when
// idle, after the next-slot table read at the list head and the update of the
// one before it. Reset (asynchronous, active low) and every capacity write
// rebuild the list through per-entry valid bits; no clearing pass is needed.
module fifo_free_list_slot_pool_top #(
    parameter int SLOT_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] slot_to_free
    input  logic        s_axis_tuser,   // [0] action
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] granted_slot, [16:8] in_use_count, rest zero
    output logic [2:0]  m_axis_tuser,   // [0] ok, [2:1] error_kind
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffsp_pkg::*;

    localparam int TBL_DEPTH = (SLOT_COUNT > 256) ? 256 : SLOT_COUNT;
    localparam logic [COUNT_W-1:0] CAP_MAX =
        COUNT_W'((SLOT_COUNT > 511) ? 511 : SLOT_COUNT);
    localparam int RST_CAP = (SLOT_COUNT > 256) ? 256 : SLOT_COUNT;
    localparam logic [SLOT_W-1:0] RST_TAIL = SLOT_W'((RST_CAP - 1) % 256);

    ffsp_state_t        state_reg, state_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [SLOT_W-1:0]  tail_reg, tail_next;
    logic               empty_reg, empty_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] limit_reg, limit_next;
    logic               action_reg, action_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [SLOT_W-1:0]  out_grant_reg, out_grant_next;
    ffsp_err_t          out_err_reg, out_err_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    ffsp_tbl_req_t      tbl_req;
    logic [SLOT_W-1:0]  tbl_rd_data;

    logic               in_fire;
    logic               cfg_wr;
    logic               exec_done;
    logic [COUNT_W-1:0] cap;
    logic [COUNT_W-1:0] wcap;

    ffsp_table #(
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    // Handshakes and capacity in effect.
    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_LIMIT);
    assign cap           = (limit_reg > CAP_MAX) ? CAP_MAX : limit_reg;
    assign wcap          = (pwdata[8:0] > CAP_MAX) ? CAP_MAX : pwdata[8:0];
    assign exec_done     = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);

    assign prdata = (paddr[2] == CFG_IDX_LIMIT) ? {23'd0, limit_reg} : 32'd0;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_count_reg, out_grant_reg};
    assign m_axis_tuser  = {out_err_reg, out_ok_reg};

    // Sequencer: read the table at the head on accept, update in the exec state once the output register is free.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        count_next     = count_reg;
        limit_next     = limit_reg;
        action_next    = action_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_grant_next = out_grant_reg;
        out_err_next   = out_err_reg;
        out_count_next = out_count_reg;

        tbl_req         = '0;
        tbl_req.rd_addr = head_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    tbl_req.rd_en = 1'b1;
                    action_next   = s_axis_tuser;
                    slot_next     = s_axis_tdata;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    out_ok_next    = 1'b0;
                    out_grant_next = '0;
                    out_err_next   = ERR_NONE;
                    if (action_reg == ACT_ALLOC)
                    begin
                        if (empty_reg)
                        begin
                            out_err_next = ERR_EXHAUSTED;
                        end
                        else
                        begin
                            out_grant_next = head_reg;
                            if (head_reg == tail_reg)
                            begin
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                head_next = tbl_rd_data;
                            end
                            if (count_reg != '1)
                            begin
                                count_next = count_reg + 9'd1;
                            end
                            out_ok_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            out_err_next = ERR_NOT_USED;
                        end
                        else if ({1'b0, slot_reg} >= cap)
                        begin
                            out_err_next = ERR_RANGE;
                        end
                        else
                        begin
                            if (empty_reg)
                            begin
                                head_next  = slot_reg;
                                empty_next = 1'b0;
                            end
                            else
                            begin
                                tbl_req.wr_en   = 1'b1;
                                tbl_req.wr_addr = tail_reg;
                                tbl_req.wr_data = slot_reg;
                            end
                            tail_next   = slot_reg;
                            count_next  = count_reg - 9'd1;
                            out_ok_next = 1'b1;
                        end
                    end
                    out_count_next = count_next;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A capacity write rebuilds the list; the user must let it arrive only while idle (not enforced).
        if (cfg_wr)
        begin
            limit_next    = pwdata[8:0];
            head_next     = '0;
            tail_next     = (wcap == '0) ? '0 : SLOT_W'(wcap - 9'd1);
            empty_next    = (wcap == '0);
            count_next    = '0;
            tbl_req.clear = 1'b1;
        end
    end

    // Control and list state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= RST_TAIL;
            empty_reg     <= 1'b0;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Transaction and result payload.
    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        slot_reg      <= slot_next;
        out_ok_reg    <= out_ok_next;
        out_grant_reg <= out_grant_next;
        out_err_reg   <= out_err_next;
        out_count_reg <= out_count_next;
    end

`ifndef NO_ASSERTIONS
    // A failed operation never hands out a slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_grant_reg == '0))
        else $error("failed result carries a granted slot");

    // Success and error code agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_ok_reg == (out_err_reg == ERR_NONE)))
        else $error("ok flag and error code disagree");

    // An accepted transaction is followed by the update cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not enter the update cycle");

    // A successful allocation below saturation adds one to the in-use count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec_done && (action_reg == ACT_ALLOC) && !empty_reg && (count_reg != '1) && !cfg_wr)
        |=> (count_reg == $past(count_reg) + 9'd1))
        else $error("allocation did not advance the in-use count");
`endif

endmodule

>>> bench/fifo_free_list_slot_pool_top_tb.sv
module fifo_free_list_slot_pool_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ffsp_pkg::*;

    localparam int POOL_SLOTS    = 256;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 80;

    // One request to the pool: allocate, or free the given slot.
    typedef struct {
        logic              act;
        logic [SLOT_W-1:0] slot;
    } pool_op_t;

    // One response from the pool.
    typedef struct {
        logic               ok;
        logic [SLOT_W-1:0]  granted;
        ffsp_err_t          err;
        logic [COUNT_W-1:0] in_use_cnt;
    } pool_result_t;

    // Receiver back-pressure modes.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_LIGHT_STALL,
        RX_HEAVY_STALL
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] slot_to_free
    logic        s_axis_tuser = 1'b0;   // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [7:0] granted_slot, [16:8] in_use_count, rest zero
    logic [2:0]  m_axis_tuser;          // [0] ok, [2:1] error_kind
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fifo_free_list_slot_pool_top #(
        .SLOT_COUNT(POOL_SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 clk = ~clk;

    // Shadow copy of the pool state.
    logic [SLOT_W-1:0]  link_table [POOL_SLOTS];
    logic [SLOT_W-1:0]  list_head;
    logic [SLOT_W-1:0]  list_tail;
    logic               list_empty;
    logic [COUNT_W-1:0] in_use;
    logic [COUNT_W-1:0] capacity_reg;

    pool_op_t     pending_ops [$];
    pool_result_t expected_results [$];

    int failures = 0;
    int offered_count = 0;
    int taken_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int rx_mode_left = 0;
    rx_mode_t rx_mode = RX_STREAM;

    function automatic int usable_slots();
        return (capacity_reg > POOL_SLOTS) ? POOL_SLOTS : int'(capacity_reg);
    endfunction

    // Chain slots 0 to capacity-1 in index order and clear the in-use count.
    function automatic void rebuild_free_list();
        int cap;
        cap = usable_slots();
        for (int i = 0; i < POOL_SLOTS; i++)
            link_table[i] = SLOT_W'(i + 1);
        list_head  = '0;
        list_tail  = (cap == 0) ? '0 : SLOT_W'(cap - 1);
        list_empty = (cap == 0);
        in_use     = '0;
    endfunction

    // Apply one accepted request to the shadow state and queue its response.
    function automatic void predict_pool_op(input logic act, input logic [SLOT_W-1:0] slot);
        pool_result_t r;
        r.ok      = 1'b0;
        r.granted = '0;
        r.err     = ERR_NONE;
        if (act == ACT_ALLOC) begin
            if (list_empty) begin
                r.err = ERR_EXHAUSTED;
            end
            else begin
                r.granted = list_head;
                if (list_head == list_tail)
                    list_empty = 1'b1;
                else
                    list_head = link_table[list_head];
                if (in_use != '1)
                    in_use = in_use + 1'b1;
                r.ok = 1'b1;
            end
        end
        else begin
            // The nothing-in-use check wins over the range check.
            if (in_use == '0) begin
                r.err = ERR_NOT_USED;
            end
            else if (int'(slot) >= usable_slots()) begin
                r.err = ERR_RANGE;
            end
            else begin
                if (list_empty) begin
                    list_head  = slot;
                    list_empty = 1'b0;
                end
                else begin
                    link_table[list_tail] = slot;
                end
                list_tail = slot;
                in_use    = in_use - 1'b1;
                r.ok      = 1'b1;
            end
        end
        r.in_use_cnt = in_use;
        expected_results.push_back(r);
    endfunction

    function automatic void push_op(input logic act, input logic [SLOT_W-1:0] slot);
        pool_op_t op;
        op.act  = act;
        op.slot = slot;
        pending_ops.push_back(op);
    endfunction

    // Sender: presents queued requests in bursts separated by random gaps.
    always @(negedge clk)
    begin : request_driver
        pool_op_t op;
        if (!s_axis_tvalid || taken_count == offered_count) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left--;
            end
            else if (pending_ops.size() != 0) begin
                op = pending_ops.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= op.act;
                s_axis_tdata  <= op.slot;
                offered_count++;
                if (burst_left > 0) begin
                    burst_left--;
                end
                else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Every request transaction updates the shadow state.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_pool_op(s_axis_tuser, s_axis_tdata);
            taken_count++;
        end
    end

    // Receiver: stalls in modes of random length, plus long hold-offs on request.
    always @(negedge clk)
    begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(10, 60);
            end
            else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_STREAM:      m_axis_tready <= 1'b1;
                RX_LIGHT_STALL: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:        m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each result transaction with the oldest expected response.
    always @(posedge clk)
    begin : result_check
        pool_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h tuser %h",
                       m_axis_tdata, m_axis_tuser);
                failures++;
            end
            else begin
                want = expected_results.pop_front();
                if (m_axis_tuser[0] !== want.ok) begin
                    $error("ok: expected %0d, actual %0d", want.ok, m_axis_tuser[0]);
                    failures++;
                end
                if (m_axis_tdata[7:0] !== want.granted) begin
                    $error("granted_slot: expected %0d, actual %0d",
                           want.granted, m_axis_tdata[7:0]);
                    failures++;
                end
                if (m_axis_tuser[2:1] !== want.err) begin
                    $error("error_kind: expected %0d, actual %0d", want.err, m_axis_tuser[2:1]);
                    failures++;
                end
                if (m_axis_tdata[16:8] !== want.in_use_cnt) begin
                    $error("in_use_count: expected %0d, actual %0d",
                           want.in_use_cnt, m_axis_tdata[16:8]);
                    failures++;
                end
            end
        end
    end

    // Wait until every request is taken and every response has come back.
    task automatic wait_until_drained();
        int waited;
        waited = 0;
        while ((pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) begin
            $error("pool did not drain: %0d requests queued, %0d responses outstanding",
                   pending_ops.size(), expected_results.size());
            failures++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {CFG_IDX_LIMIT, 2'b00};
        pwdata  <= {23'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        capacity_reg = value;
        rebuild_free_list();
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random phase: mostly allocations and frees of slots actually held, with
    // fill and drain trends so both exhaustion and an empty pool are reached.
    task automatic run_phase(input logic [COUNT_W-1:0] cap_value, input int n_items,
                             input bit long_hold);
        logic [SLOT_W-1:0] free_shadow [$];
        logic [SLOT_W-1:0] held_shadow [$];
        logic [SLOT_W-1:0] s;
        int cap;
        int fill_bias;
        int k;
        write_capacity(cap_value);
        cap = (cap_value > POOL_SLOTS) ? POOL_SLOTS : int'(cap_value);
        for (int i = 0; i < cap; i++)
            free_shadow.push_back(SLOT_W'(i));
        fill_bias = 85;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 6) begin
                // Noise: a free of any slot, possibly out of range or not held.
                push_op(ACT_FREE, SLOT_W'($urandom));
            end
            else if ($urandom_range(0, 99) < fill_bias) begin
                push_op(ACT_ALLOC, SLOT_W'($urandom));
                if (free_shadow.size() != 0)
                    held_shadow.push_back(free_shadow.pop_front());
                else
                    fill_bias = 15;
            end
            else if (held_shadow.size() != 0) begin
                k = $urandom_range(0, held_shadow.size() - 1);
                s = held_shadow[k];
                held_shadow.delete(k);
                free_shadow.push_back(s);
                push_op(ACT_FREE, s);
                if (held_shadow.size() == 0)
                    fill_bias = 85;
            end
            else begin
                push_op(ACT_FREE, SLOT_W'($urandom));
                fill_bias = 85;
            end
            if ($urandom_range(0, 49) == 0)
                fill_bias = 100 - fill_bias;
            // Halfway through, optionally back up the output, then let the pool drain.
            if (i == n_items / 2) begin
                if (long_hold) begin
                    @(posedge clk);
                    hold_requests++;
                end
                wait_until_drained();
            end
        end
        wait_until_drained();
    endtask

    initial begin
        capacity_reg = LIMIT_RESET;
        rebuild_free_list();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset capacity: frees with nothing in use, in-order grants, double free.
        push_op(ACT_FREE, 8'hFF);
        push_op(ACT_FREE, 8'h00);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_ALLOC, 8'hFF);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_FREE, 8'h01);
        push_op(ACT_FREE, 8'h00);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_FREE, 8'h02);
        push_op(ACT_FREE, 8'h02);
        wait_until_drained();

        // Two slots: exhaustion, range errors, free into an empty list.
        write_capacity(9'd2);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_FREE, 8'h02);
        push_op(ACT_FREE, 8'hFF);
        push_op(ACT_FREE, 8'h01);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_FREE, 8'h00);
        push_op(ACT_FREE, 8'h01);
        push_op(ACT_FREE, 8'h00);
        wait_until_drained();

        // No slots at all.
        write_capacity(9'd0);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_FREE, 8'h00);
        wait_until_drained();

        // Single slot: head equals tail on every grant.
        write_capacity(9'd1);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_ALLOC, 8'h00);
        push_op(ACT_FREE, 8'h01);
        push_op(ACT_FREE, 8'h00);
        wait_until_drained();

        // Random phases over small, full and saturating capacities.
        run_phase(9'd256, 400, 1'b1);
        run_phase(9'd0, 30, 1'b0);
        run_phase(9'd1, 80, 1'b0);
        run_phase(9'd2, 100, 1'b0);
        run_phase(9'd511, 300, 1'b1);
        run_phase(9'd300, 120, 1'b0);
        run_phase(9'd255, 120, 1'b0);
        run_phase(9'd5, 100, 1'b0);
        run_phase(COUNT_W'($urandom_range(3, 40)), 50, 1'b0);
        run_phase(COUNT_W'($urandom_range(3, 40)), 50, 1'b0);

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ffsp_pkg.sv
hw/rtl/ffsp_table.sv
hw/rtl/fifo_free_list_slot_pool_top.sv
bench/fifo_free_list_slot_pool_top_tb.sv
